// ===== rtl/core/bitmap_store_engine_defines.svh =====
// assertion macros for the bit store engine
`ifndef BITMAP_STORE_ENGINE_DEFINES_SVH
`define BITMAP_STORE_ENGINE_DEFINES_SVH

// consequent checked in the same cycle
`define BSE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bit store engine: same-cycle check failed");

// consequent checked in the next cycle
`define BSE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bit store engine: next-cycle check failed");

`endif

// ===== rtl/core/bse_pkg.sv =====
// shared types and constants of the bit store engine
package bse_pkg;

    localparam int IDX_W   = 12;
    localparam int CFG_W   = 13;
    localparam int CNT_W   = 13;
    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;

    localparam int INDEX_LIMIT = 4096;

    localparam logic [CFG_W-1:0]   BITS_IN_USE_RESET = 13'd4096;
    localparam logic [PADDR_W-1:0] ADDR_BITS_IN_USE  = 2'd0;

    localparam logic [2:0] OP_SET     = 3'd0;
    localparam logic [2:0] OP_CLR     = 3'd1;
    localparam logic [2:0] OP_READ    = 3'd2;
    localparam logic [2:0] OP_WRITE   = 3'd3;
    localparam logic [2:0] OP_COUNT   = 3'd4;
    localparam logic [2:0] OP_CLR_ALL = 3'd5;
    localparam logic [2:0] OP_FIND    = 3'd6;

    typedef struct packed {
        logic [2:0]       op;
        logic [IDX_W-1:0] bit_index;
        logic             bit_value;
    } bse_in_t;

    typedef struct packed {
        logic             status;
        logic             read_bit;
        logic [CNT_W-1:0] set_count;
        logic             found;
        logic [IDX_W-1:0] found_index;
    } bse_out_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_RD,
        ST_WR,
        ST_CNT,
        ST_FND,
        ST_CLR,
        ST_FIN
    } bse_state_t;

    typedef struct packed {
        logic start;
        logic load;
        logic rd_idx;
        logic rd_scan;
        logic wr_bit;
        logic wr_zero;
        logic scan_inc;
    } bse_cmd_t;

    typedef struct packed {
        logic [2:0] in_op;
        logic       in_oor;
        logic       out_free;
        logic       cnt_end;
        logic       fnd_end;
        logic       found;
        logic       clr_last;
    } bse_stat_t;

endpackage

// ===== rtl/core/bse_ctrl.sv =====
// controller state machine of the bit store engine
module bse_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bse_pkg::bse_stat_t  stat,
    output bse_pkg::bse_cmd_t   cmd
);
    import bse_pkg::*;

    bse_state_t state_reg;
    bse_state_t state_next;
    bse_state_t dispatch;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    // first state of a freshly taken item
    always_comb begin
        if (stat.in_oor) begin
            dispatch = ST_FIN;
        end else begin
            case (stat.in_op)
                OP_SET, OP_CLR, OP_READ, OP_WRITE: dispatch = ST_RD;
                OP_COUNT:                          dispatch = ST_CNT;
                OP_CLR_ALL:                        dispatch = ST_CLR;
                OP_FIND:                           dispatch = ST_FND;
                default:                           dispatch = ST_FIN;
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT: begin
                if (stat.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (cmd.start) begin
                    state_next = dispatch;
                end
            end
            ST_RD: begin
                state_next = ST_WR;
            end
            ST_WR, ST_FIN: begin
                if (cmd.start) begin
                    state_next = dispatch;
                end else if (cmd.load) begin
                    state_next = ST_IDLE;
                end
            end
            ST_CNT: begin
                if (stat.cnt_end) begin
                    state_next = ST_FIN;
                end
            end
            ST_FND: begin
                if (stat.found || stat.fnd_end) begin
                    state_next = ST_FIN;
                end
            end
            ST_CLR: begin
                if (stat.clr_last) begin
                    state_next = ST_FIN;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd = '0;
        case (state_reg)
            ST_INIT: begin
                cmd.wr_zero  = 1'b1;
                cmd.scan_inc = 1'b1;
            end
            ST_RD: begin
                cmd.rd_idx = 1'b1;
            end
            ST_WR: begin
                cmd.wr_bit = 1'b1;
                cmd.load   = stat.out_free;
            end
            ST_FIN: begin
                cmd.load = stat.out_free;
            end
            ST_CNT: begin
                cmd.rd_scan  = !stat.cnt_end;
                cmd.scan_inc = !stat.cnt_end;
            end
            ST_FND: begin
                cmd.rd_scan  = !(stat.found || stat.fnd_end);
                cmd.scan_inc = !(stat.found || stat.fnd_end);
            end
            ST_CLR: begin
                cmd.wr_zero  = 1'b1;
                cmd.scan_inc = 1'b1;
            end
            default: begin
                cmd = '0;
            end
        endcase
        s_ready   = (state_reg == ST_IDLE) || cmd.load;
        cmd.start = s_ready && s_valid;
    end

endmodule

// ===== rtl/core/bse_dp.sv =====
// datapath of the bit store engine: byte store, scan counter, result register
module bse_dp #(
    parameter int MAX_BITS = 4096
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bse_pkg::bse_in_t              s_data,
    input  logic [bse_pkg::CFG_W-1:0]     bits_in_use,
    input  bse_pkg::bse_cmd_t             cmd,
    output bse_pkg::bse_stat_t            stat,
    output logic                          m_valid,
    input  logic                          m_ready,
    output bse_pkg::bse_out_t             m_data
);
    import bse_pkg::*;

    localparam int STORE_BYTES = (MAX_BITS + 7) / 8;
    localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int CW = (AW + 1 > 11) ? AW + 1 : 11;
    localparam int PW = CW + 3;

    logic [7:0] mem [STORE_BYTES];

    logic [7:0]       rd_data_reg;
    logic             rd_vld_reg;
    logic [CW-1:0]    rd_addr_reg;
    logic [CW-1:0]    scan_reg;
    logic [CW-1:0]    scan_next;
    logic [2:0]       op_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             val_reg;
    logic             oor_reg;
    logic [CNT_W-1:0] count_reg;
    logic             found_reg;
    logic [IDX_W-1:0] fidx_reg;
    logic             m_valid_reg;
    logic             m_valid_next;
    bse_out_t         m_data_reg;
    bse_out_t         res;

    logic [CFG_W-1:0] n;
    logic [CFG_W-1:0] lim;
    logic [10:0]      nbytes;
    logic [9:0]       limb;
    logic             in_indexed;

    logic [AW-1:0] idx_byte;
    logic [AW-1:0] scan_addr;
    logic [AW-1:0] rd_addr;
    logic          rd_en;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [7:0]    bit_mask;
    logic          bit_new;
    logic [7:0]    new_byte;

    logic [7:0]    cnt_mask;
    logic [7:0]    fnd_mask;
    logic [7:0]    fnd_bits;
    logic [3:0]    pop;
    logic [2:0]    first_j;
    logic [PW-1:0] pos;

    // effective size and search bounds
    assign n      = (int'(bits_in_use) > MAX_BITS) ? CFG_W'(MAX_BITS) : bits_in_use;
    assign lim    = (n > CFG_W'(INDEX_LIMIT)) ? CFG_W'(INDEX_LIMIT) : n;
    assign nbytes = 11'((14'(n) + 14'd7) >> 3);
    assign limb   = 10'((14'(lim) + 14'd7) >> 3);

    assign in_indexed = (s_data.op == OP_SET) || (s_data.op == OP_CLR) ||
                        (s_data.op == OP_READ) || (s_data.op == OP_WRITE) ||
                        (s_data.op == OP_FIND);

    assign stat.in_op    = s_data.op;
    assign stat.in_oor   = in_indexed && ({1'b0, s_data.bit_index} >= n);
    assign stat.out_free = !m_valid_reg || m_ready;
    assign stat.cnt_end  = scan_reg >= CW'(nbytes);
    assign stat.fnd_end  = scan_reg >= CW'(limb);
    assign stat.found    = found_reg;
    assign stat.clr_last = scan_reg == CW'(STORE_BYTES - 1);

    // byte access
    assign idx_byte  = AW'(idx_reg >> 3);
    assign scan_addr = scan_reg[AW-1:0];
    assign rd_en     = cmd.rd_idx || cmd.rd_scan;
    assign rd_addr   = cmd.rd_idx ? idx_byte : scan_addr;

    assign bit_mask = 8'h01 << idx_reg[2:0];
    assign bit_new  = (op_reg == OP_SET) || ((op_reg == OP_WRITE) && val_reg);
    assign new_byte = bit_new ? (rd_data_reg | bit_mask) : (rd_data_reg & ~bit_mask);

    assign wr_en   = (cmd.wr_bit && (op_reg != OP_READ)) || cmd.wr_zero;
    assign wr_addr = cmd.wr_zero ? scan_addr : idx_byte;
    assign wr_data = cmd.wr_zero ? 8'h00 : new_byte;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
            rd_addr_reg <= scan_reg;
        end
    end

    // per-bit windows of the byte just read
    always_comb begin
        for (int j = 0; j < 8; j++) begin
            pos         = {rd_addr_reg, 3'(j)};
            cnt_mask[j] = pos < PW'(n);
            fnd_mask[j] = (pos >= PW'(idx_reg)) && (pos < PW'(lim));
        end
    end

    assign fnd_bits = rd_data_reg & fnd_mask;

    always_comb begin
        pop = 4'd0;
        for (int j = 0; j < 8; j++) begin
            pop = pop + 4'(rd_data_reg[j] & cnt_mask[j]);
        end
    end

    always_comb begin
        first_j = 3'd0;
        for (int j = 7; j >= 0; j--) begin
            if (fnd_bits[j]) begin
                first_j = 3'(j);
            end
        end
    end

    // scan counter and control flags
    always_comb begin
        scan_next = scan_reg;
        if (cmd.start) begin
            scan_next = (s_data.op == OP_FIND) ? CW'(s_data.bit_index >> 3) : '0;
        end else if (cmd.scan_inc) begin
            scan_next = scan_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg    <= '0;
            rd_vld_reg  <= 1'b0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            scan_reg    <= scan_next;
            rd_vld_reg  <= rd_en;
            m_valid_reg <= m_valid_next;
            if (cmd.start) begin
                found_reg <= 1'b0;
            end else if (rd_vld_reg && (op_reg == OP_FIND) && !found_reg && (|fnd_bits)) begin
                found_reg <= 1'b1;
            end
        end
    end

    // item and accumulators
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            op_reg    <= s_data.op;
            idx_reg   <= s_data.bit_index;
            val_reg   <= s_data.bit_value;
            oor_reg   <= stat.in_oor;
            count_reg <= '0;
        end else begin
            if (rd_vld_reg && (op_reg == OP_COUNT)) begin
                count_reg <= count_reg + CNT_W'(pop);
            end
            if (rd_vld_reg && (op_reg == OP_FIND) && !found_reg && (|fnd_bits)) begin
                fidx_reg <= IDX_W'({rd_addr_reg, first_j});
            end
        end
    end

    // result beat
    always_comb begin
        res             = '0;
        res.status      = oor_reg;
        res.read_bit    = (op_reg == OP_READ) && !oor_reg && rd_data_reg[idx_reg[2:0]];
        res.set_count   = (op_reg == OP_COUNT) ? count_reg : '0;
        res.found       = (op_reg == OP_FIND) && found_reg;
        res.found_index = ((op_reg == OP_FIND) && found_reg) ? fidx_reg : '0;
    end

    always_comb begin
        if (cmd.load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/core/bitmap_store_engine.sv =====
// top level of the bit store engine: config register, controller and datapath
//
//   channel | direction | handshake              | beat
//   s_      | in        | s_valid / s_ready      | bse_in_t  (op, bit_index, bit_value)
//   m_      | out       | m_valid / m_ready      | bse_out_t (status, read_bit, set_count,
//           |           |                        |            found, found_index)
//   apb     | in        | psel, penable, pready  | bits_in_use at byte address 0
//
// set, clear, read and write first read the store byte, then set, clear and write modify and write it back
// count reads one store byte per cycle over the valid bits
// find next set reads one byte a cycle from the start byte up to the limit, until a set bit is found
// clear all zeroes every store byte, one byte written per cycle
// after reset a clearing pass zeroes every store byte before s_ready rises
// a stalled m_ beat holds the finishing item; the next item is taken as the beat frees
`include "bitmap_store_engine_defines.svh"

module bitmap_store_engine #(
    parameter int MAX_BITS = 4096
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  bse_pkg::bse_in_t              s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output bse_pkg::bse_out_t             m_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bse_pkg::PADDR_W-1:0]   paddr,
    input  logic [bse_pkg::PDATA_W-1:0]   pwdata,
    output logic [bse_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import bse_pkg::*;

    logic [CFG_W-1:0] bits_in_use_reg;
    bse_cmd_t         cmd;
    bse_stat_t        stat;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bits_in_use_reg <= BITS_IN_USE_RESET;
        end else if (psel && penable && pwrite && pready && (paddr == ADDR_BITS_IN_USE)) begin
            bits_in_use_reg <= pwdata[CFG_W-1:0];
        end
    end

    always_comb begin
        if (paddr == ADDR_BITS_IN_USE) begin
            prdata = {{(PDATA_W - CFG_W){1'b0}}, bits_in_use_reg};
        end else begin
            prdata = '0;
        end
    end

    bse_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bse_dp #(
        .MAX_BITS (MAX_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_data      (s_data),
        .bits_in_use (bits_in_use_reg),
        .cmd         (cmd),
        .stat        (stat),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    `BSE_ASSERT_NOW(a_no_overwrite, m_valid && !m_ready, !cmd.load)
    `BSE_ASSERT_NOW(a_one_mem_op, 1'b1, $onehot0({cmd.rd_idx, cmd.rd_scan, cmd.wr_bit, cmd.wr_zero}))
    `BSE_ASSERT_NEXT(a_load_shows, cmd.load, m_valid)

endmodule

// ===== tb/tb_bitmap_store_engine.sv =====
// self-checking testbench for the bit store engine: directed table, then random phases
module tb_bitmap_store_engine;
    import bse_pkg::*;

    localparam int STORE_BITS = 4096;
    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam int N_DIRECTED = 25;
    localparam int SEG_ITEMS = 92;
    localparam int SETTLE_CYCLES = 600;
    localparam int unsigned CYCLE_LIMIT = 2000000;

    typedef struct {
        logic [CFG_W-1:0] size;
        bse_in_t          item;
        bit               typed;
        bse_out_t         want;
    } dir_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    bse_in_t              s_data;
    logic                 m_valid;
    logic                 m_ready;
    bse_out_t             m_data;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    logic [STORE_BITS-1:0] model_bits;
    logic [CFG_W-1:0]      model_size;
    bse_out_t              pending_results[$];
    dir_row_t              dir_rows[N_DIRECTED];
    int                    s_idle_pct;
    int                    m_idle_pct;
    int                    mismatch_count;
    int unsigned           cycle_count;

    bitmap_store_engine dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 100) $display("mismatch: %s", what);
    endtask

    function automatic int valid_count();
        return (model_size > STORE_BITS) ? STORE_BITS : int'(model_size);
    endfunction

    function automatic bse_out_t predict_result(bse_in_t item);
        bse_out_t r;
        int n;
        r = '0;
        n = valid_count();
        if ((item.op <= OP_WRITE || item.op == OP_FIND) && int'(item.bit_index) >= n) begin
            r.status = 1'b1;
        end else begin
            case (item.op)
                OP_SET: model_bits[item.bit_index] = 1'b1;
                OP_CLR: model_bits[item.bit_index] = 1'b0;
                OP_READ: r.read_bit = model_bits[item.bit_index];
                OP_WRITE: model_bits[item.bit_index] = item.bit_value;
                OP_COUNT: begin
                    for (int i = 0; i < n; i++) r.set_count += model_bits[i];
                end
                OP_CLR_ALL: model_bits = '0;
                OP_FIND: begin
                    for (int i = int'(item.bit_index); i < n; i++) begin
                        if (model_bits[i]) begin
                            r.found = 1'b1;
                            r.found_index = i[IDX_W-1:0];
                            break;
                        end
                    end
                end
                default: ;
            endcase
        end
        return r;
    endfunction

    function automatic dir_row_t mk_row(int size, logic [2:0] op, int idx,
                                        int val, int typed, int st, int rb, int cnt,
                                        int fnd, int fidx);
        dir_row_t row;
        row.size = CFG_W'(size);
        row.item.op = op;
        row.item.bit_index = idx[IDX_W-1:0];
        row.item.bit_value = val[0];
        row.typed = typed[0];
        row.want.status = st[0];
        row.want.read_bit = rb[0];
        row.want.set_count = cnt[CNT_W-1:0];
        row.want.found = fnd[0];
        row.want.found_index = fidx[IDX_W-1:0];
        return row;
    endfunction

    function automatic bse_in_t random_item();
        bse_in_t item;
        int n;
        int pick;
        n = valid_count();
        pick = $urandom_range(0, 99);
        if (pick < 25) item.op = OP_SET;
        else if (pick < 37) item.op = OP_CLR;
        else if (pick < 55) item.op = OP_READ;
        else if (pick < 70) item.op = OP_WRITE;
        else if (pick < 77) item.op = OP_COUNT;
        else if (pick < 80) item.op = OP_CLR_ALL;
        else if (pick < 95) item.op = OP_FIND;
        else item.op = OP_UNUSED;
        if (n < INDEX_LIMIT && $urandom_range(0, 99) < 15)
            item.bit_index = IDX_W'($urandom_range(n, INDEX_LIMIT - 1));
        else
            item.bit_index = IDX_W'($urandom_range(0, n - 1));
        item.bit_value = 1'($urandom_range(0, 1));
        return item;
    endfunction

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_item(input bse_in_t item, input bit typed, input bse_out_t want);
        bse_out_t predicted;
        while ($urandom_range(0, 99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= item;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_result(item);
        pending_results.push_back(typed ? want : predicted);
        @(negedge aclk);
    endtask

    task automatic wait_results_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic write_bits_in_use(input logic [CFG_W-1:0] size);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_BITS_IN_USE;
        pwdata <= {{(PDATA_W-CFG_W){1'b0}}, size};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        model_size = size;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== {{(PDATA_W-CFG_W){1'b0}}, size})
            report_mismatch($sformatf("bits_in_use read %0d, wrote %0d", prdata, size));
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_beat(input bse_out_t got);
        bse_out_t want;
        if (pending_results.size() == 0) begin
            report_mismatch("result beat with nothing pending");
            return;
        end
        want = pending_results.pop_front();
        if (got.status !== want.status)
            report_mismatch($sformatf("status %0b, want %0b", got.status, want.status));
        if (got.read_bit !== want.read_bit)
            report_mismatch($sformatf("read_bit %0b, want %0b", got.read_bit, want.read_bit));
        if (got.set_count !== want.set_count)
            report_mismatch($sformatf("set_count %0d, want %0d",
                                      got.set_count, want.set_count));
        if (got.found !== want.found)
            report_mismatch($sformatf("found %0b, want %0b", got.found, want.found));
        if (got.found_index !== want.found_index)
            report_mismatch($sformatf("found_index %0d, want %0d",
                                      got.found_index, want.found_index));
    endtask

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= m_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) check_beat(m_data);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_bitmap_store_engine NOT OK");
            $finish;
        end
    end

    initial begin
        logic [CFG_W-1:0] seg_size;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        model_bits = '0;
        model_size = BITS_IN_USE_RESET;
        mismatch_count = 0;
        cycle_count = 0;
        s_idle_pct = 33;
        m_idle_pct = 63;

        dir_rows = '{
            mk_row(0,    OP_COUNT,   0,    0, 1, 0, 0, 0, 0, 0),
            mk_row(0,    OP_READ,    0,    0, 1, 0, 0, 0, 0, 0),
            mk_row(0,    OP_FIND,    0,    0, 1, 0, 0, 0, 0, 0),
            mk_row(0,    OP_UNUSED,  4095, 1, 1, 0, 0, 0, 0, 0),
            mk_row(0,    OP_SET,     0,    0, 1, 0, 0, 0, 0, 0),
            mk_row(0,    OP_SET,     4095, 1, 1, 0, 0, 0, 0, 0),
            mk_row(0,    OP_READ,    4095, 0, 1, 0, 1, 0, 0, 0),
            mk_row(0,    OP_COUNT,   0,    0, 1, 0, 0, 2, 0, 0),
            mk_row(0,    OP_FIND,    1,    0, 1, 0, 0, 0, 1, 4095),
            mk_row(0,    OP_WRITE,   2730, 1, 0, 0, 0, 0, 0, 0),
            mk_row(0,    OP_WRITE,   4095, 0, 0, 0, 0, 0, 0, 0),
            mk_row(0,    OP_CLR,     0,    1, 0, 0, 0, 0, 0, 0),
            mk_row(0,    OP_FIND,    0,    0, 0, 0, 0, 0, 0, 0),
            mk_row(1,    OP_SET,     0,    0, 1, 0, 0, 0, 0, 0),
            mk_row(0,    OP_SET,     1,    0, 1, 1, 0, 0, 0, 0),
            mk_row(0,    OP_READ,    4095, 1, 1, 1, 0, 0, 0, 0),
            mk_row(0,    OP_WRITE,   1,    1, 1, 1, 0, 0, 0, 0),
            mk_row(0,    OP_CLR,     1,    0, 1, 1, 0, 0, 0, 0),
            mk_row(0,    OP_FIND,    1,    0, 1, 1, 0, 0, 0, 0),
            mk_row(0,    OP_COUNT,   0,    0, 1, 0, 0, 1, 0, 0),
            mk_row(4096, OP_READ,    2730, 0, 1, 0, 1, 0, 0, 0),
            mk_row(0,    OP_COUNT,   1365, 1, 0, 0, 0, 0, 0, 0),
            mk_row(0,    OP_CLR_ALL, 4095, 1, 1, 0, 0, 0, 0, 0),
            mk_row(0,    OP_COUNT,   0,    0, 1, 0, 0, 0, 0, 0),
            mk_row(0,    OP_FIND,    0,    0, 1, 0, 0, 0, 0, 0)
        };

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].size != 0) begin
                wait_results_drained();
                write_bits_in_use(dir_rows[r].size);
            end
            send_item(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].want);
        end

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin s_idle_pct = 33; m_idle_pct = 63; end
                1: begin s_idle_pct = 63; m_idle_pct = 33; end
                default: begin s_idle_pct = 0; m_idle_pct = 0; end
            endcase
            for (int seg = 0; seg < 4; seg++) begin
                // mostly small sizes, the full store only now and then
                case (seg)
                    0: seg_size = CFG_W'($urandom_range(1, 64));
                    1: seg_size = (ph == 0) ? 13'd4096 :
                                  (ph == 1) ? 13'd4095 : CFG_W'($urandom_range(1, 4096));
                    2: seg_size = CFG_W'($urandom_range(1, 200));
                    default: seg_size = (ph == 2) ? 13'd1 : CFG_W'($urandom_range(8, 40));
                endcase
                wait_results_drained();
                write_bits_in_use(seg_size);
                for (int k = 0; k < SEG_ITEMS; k++) begin
                    if (seg == 2 && k == SEG_ITEMS / 2) wait_results_drained();
                    send_item(random_item(), 1'b0, '0);
                end
            end
        end

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("tb_bitmap_store_engine OK");
        else
            $display("tb_bitmap_store_engine NOT OK");
        $finish;
    end

endmodule
